FILE: rtl/priority_resource_grant_scheduler_core_defines.svh
// Assertion macros for the grant scheduler
`ifndef PRIORITY_RESOURCE_GRANT_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_RESOURCE_GRANT_SCHEDULER_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define PRGS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PRGS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/prgs_pkg.sv
// Package: sizes, codes, queue slot type and FSM states of the grant scheduler
package prgs_pkg;
    localparam int MAX_GPUS    = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int UW = $clog2(MAX_GPUS);
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int NQ = MAX_GPUS + 2;          // unit queues, any queue, bus queue
    localparam int QW = $clog2(NQ);
    localparam int RAMD = NQ * QUEUE_DEPTH;
    localparam int RAMA = $clog2(RAMD);
    localparam logic [QW-1:0] Q_ANY = QW'(MAX_GPUS);
    localparam logic [QW-1:0] Q_BUS = QW'(MAX_GPUS + 1);

    localparam logic [1:0] K_GREQ = 2'd0;
    localparam logic [1:0] K_BREQ = 2'd1;
    localparam logic [1:0] K_GFIN = 2'd2;
    localparam logic [1:0] K_BFIN = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_QUEUED = 3'd1;
    localparam logic [2:0] ST_IDLED  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_BADIDX = 3'd4;

    typedef struct packed {
        logic [15:0] client;
        logic [7:0]  prio;
        logic [7:0]  count;
        logic [15:0] stamp;
    } slot_t;
    localparam int SLOTW = $bits(slot_t);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SCAN2, S_DECIDE, S_WRITE, S_OUT
    } state_t;
endpackage

FILE: rtl/prgs_ram.sv
// Generic single-port-write, registered-read RAM
module prgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/priority_resource_grant_scheduler_core.sv
// Top level of the priority resource grant scheduler
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata request/finish item
// m_      | out | m_tvalid/m_tready  | m_tuser bus flag, m_tdata grant result item
// cfg     | in  | cfg_we             | cfg_wdata gpus_in_use
//
// One item at a time. A request goes from acceptance through S_DECIDE to the result
// item, through S_WRITE as well when a queue write follows. A queue scan reads the
// QUEUE_DEPTH slots through the one RAM read port, one per cycle, plus the registered
// read and a close. Bus finish: one scan; unit finish: two scans, unit then any queue.
// Valid bits are flip-flops cleared by reset; RAM contents need no clear.
// s_tready is low from acceptance until the cycle after the result item is taken.
// m_tvalid holds with stable data while m_tready is low.
`include "priority_resource_grant_scheduler_core_defines.svh"
module priority_resource_grant_scheduler_core
    import prgs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    // any_gpu[0] gpu_index[2:1] client_id[18:3] priority_req[26:19]
    // grant_count[34:27], zero fill to 40
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // grant_is_bus[0]
    output logic        m_tuser,
    // grant[0] grant_client[16:1] grant_unit[18:17] reply_any[19]
    // reply_priority[27:20] status[30:28], zero fill to 32
    output logic [31:0] m_tdata
);
    state_t state_reg, state_next;
    logic [2:0] cfg_reg;
    logic [MAX_GPUS-1:0] gpu_busy_reg, gpu_busy_next;
    logic bus_busy_reg, bus_busy_next;
    logic [QUEUE_DEPTH-1:0] valid_reg [NQ];
    logic [15:0] stamp_reg, stamp_next;

    logic [1:0]  kind_reg;
    logic        any_reg;
    logic [1:0]  idx_reg;
    logic [15:0] client_reg;
    logic [7:0]  prio_reg, count_reg;
    // bit 32 is the bus flag for m_tuser
    logic [32:0] out_reg, out_next;

    // bus state as seen at acceptance, for the rest-of-count push
    logic bus_busy_reg_q;

    // scan engine
    logic [QW-1:0] sq_reg, sq_next;           // queue being scanned
    logic [SW:0]   sc_reg, sc_next;           // read address counter
    logic          rv_reg;                    // RAM data valid for slot rs_reg
    logic [SW-1:0] rs_reg;
    logic          bf_reg, bf_next;           // best found in current queue
    logic [SW-1:0] bi_reg, bi_next;
    slot_t         bs_reg, bs_next;
    logic [15:0]   ba_reg, ba_next;
    // first-queue result held for unit finish
    logic          uf_reg, uf_next;
    logic [SW-1:0] ui_reg, ui_next;
    slot_t         us_reg, us_next;

    // RAM
    logic          we;
    logic [RAMA-1:0] waddr, raddr;
    slot_t         wdata, rdata;
    logic [SLOTW-1:0] rdata_raw;
    prgs_ram #(.WIDTH(SLOTW), .DEPTH(RAMD)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_raw)
    );
    assign rdata = slot_t'(rdata_raw);

    // effective unit count
    logic [UW:0] n_eff;
    assign n_eff = (cfg_reg > 3'(MAX_GPUS)) ? (UW+1)'(MAX_GPUS) : (UW+1)'(cfg_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg[31:0];
    assign m_tuser  = out_reg[32];

    // lowest idle unit below n_eff
    logic          free_found;
    logic [UW-1:0] free_unit;
    always_comb begin
        free_found = 1'b0;
        free_unit  = '0;
        for (int i = MAX_GPUS - 1; i >= 0; i--) begin
            if ((UW+1)'(i) < n_eff && !gpu_busy_reg[i]) begin
                free_found = 1'b1;
                free_unit  = UW'(i);
            end
        end
    end

    // first free slot of a queue (priority encoder over valid bits)
    function automatic logic [SW:0] first_free(input logic [QUEUE_DEPTH-1:0] v);
        logic [SW:0] r;
        r = {1'b1, {SW{1'b0}}};
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
            if (!v[i]) r = {1'b0, SW'(i)};
        return r;
    endfunction

    logic [QW-1:0] req_q;   // queue a request goes to
    always_comb begin
        if (kind_reg == K_BREQ)      req_q = Q_BUS;
        else if (any_reg)            req_q = Q_ANY;
        else                         req_q = QW'(idx_reg);
    end
    logic [SW:0] ff;
    assign ff = first_free(valid_reg[req_q]);

    logic [15:0] age;
    assign age = stamp_reg - rdata.stamp;
    logic idx_bad;
    assign idx_bad = ({1'b0, idx_reg} >= n_eff);

    // valid-bit updates from the sequencer
    logic          vset, vclr;
    logic [QW-1:0] vq;
    logic [SW-1:0] vs;

    always_comb begin
        state_next    = state_reg;
        gpu_busy_next = gpu_busy_reg;
        bus_busy_next = bus_busy_reg;
        stamp_next    = stamp_reg;
        out_next      = out_reg;
        sq_next = sq_reg; sc_next = sc_reg;
        bf_next = bf_reg; bi_next = bi_reg; bs_next = bs_reg; ba_next = ba_reg;
        uf_next = uf_reg; ui_next = ui_reg; us_next = us_reg;
        we = 1'b0; waddr = '0; wdata = '0;
        raddr = RAMA'({sq_reg, sc_reg[SW-1:0]});
        vset = 1'b0; vclr = 1'b0; vq = '0; vs = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECIDE;
                    sc_next = '0; bf_next = 1'b0; uf_next = 1'b0;
                    if (s_tuser == K_GFIN) begin
                        sq_next = QW'(s_tdata[2:1]);
                        state_next = S_SCAN;
                    end else if (s_tuser == K_BFIN) begin
                        sq_next = Q_BUS;
                        state_next = S_SCAN2;
                    end
                end
            end
            S_SCAN, S_SCAN2: begin
                if (!sc_reg[SW]) sc_next = sc_reg + 1'b1;
                if (rv_reg && valid_reg[sq_reg][rs_reg]) begin
                    if (!bf_reg || rdata.prio > bs_reg.prio ||
                        (rdata.prio == bs_reg.prio && age > ba_reg)) begin
                        bf_next = 1'b1; bi_next = rs_reg;
                        bs_next = rdata; ba_next = age;
                    end
                end
                if (sc_reg[SW] && !rv_reg) begin
                    if (state_reg == S_SCAN) begin
                        uf_next = bf_next; ui_next = bi_next; us_next = bs_next;
                        bf_next = 1'b0; sc_next = '0; sq_next = Q_ANY;
                        state_next = S_SCAN2;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                out_next = '0;
                out_next[27:20] = prio_reg;
                state_next = S_OUT;
                case (kind_reg)
                    K_GREQ: begin
                        if (any_reg && free_found) begin
                            gpu_busy_next[free_unit] = 1'b1;
                            out_next[0] = 1'b1; out_next[16:1] = client_reg;
                            out_next[18:17] = 2'(free_unit); out_next[19] = 1'b1;
                        end else if (!any_reg && idx_bad) begin
                            out_next[30:28] = ST_BADIDX;
                        end else if (!any_reg && !gpu_busy_reg[UW'(idx_reg)]) begin
                            gpu_busy_next[UW'(idx_reg)] = 1'b1;
                            out_next[0] = 1'b1; out_next[16:1] = client_reg;
                            out_next[18:17] = idx_reg;
                        end else begin
                            out_next[30:28] = ff[SW] ? ST_FULL : ST_QUEUED;
                            state_next = S_WRITE;
                        end
                    end
                    K_BREQ: begin
                        if (bus_busy_reg) begin
                            out_next[30:28] = ff[SW] ? ST_FULL : ST_QUEUED;
                            state_next = S_WRITE;
                        end else begin
                            bus_busy_next = 1'b1;
                            out_next[0] = 1'b1; out_next[16:1] = client_reg;
                            out_next[32] = 1'b1;
                            if (count_reg > 8'd1) begin
                                out_next[30:28] = ff[SW] ? ST_FULL : ST_OK;
                                state_next = S_WRITE;
                            end
                        end
                    end
                    K_GFIN: begin
                        if (idx_bad) begin
                            out_next[30:28] = ST_BADIDX;
                        end else if (!uf_reg && !bf_reg) begin
                            gpu_busy_next[UW'(idx_reg)] = 1'b0;
                            out_next[30:28] = ST_IDLED;
                        end else begin
                            gpu_busy_next[UW'(idx_reg)] = 1'b1;
                            out_next[0] = 1'b1; out_next[18:17] = idx_reg;
                            state_next = S_WRITE;
                            if (uf_reg && (!bf_reg || us_reg.prio > bs_reg.prio)) begin
                                out_next[16:1] = us_reg.client;
                                sq_next = QW'(idx_reg);
                                bi_next = ui_reg; bs_next = us_reg;
                            end else begin
                                out_next[16:1] = bs_reg.client;
                                out_next[19] = 1'b1;
                                sq_next = Q_ANY;
                            end
                        end
                    end
                    default: begin
                        if (!bf_reg) begin
                            bus_busy_next = 1'b0;
                            out_next[30:28] = ST_IDLED;
                        end else begin
                            bus_busy_next = 1'b1;
                            out_next[0] = 1'b1; out_next[16:1] = bs_reg.client;
                            out_next[32] = 1'b1;
                            state_next = S_WRITE;
                        end
                    end
                endcase
            end
            S_WRITE: begin
                state_next = S_OUT;
                if (kind_reg == K_GREQ || kind_reg == K_BREQ) begin
                    if (!ff[SW]) begin
                        we = 1'b1; waddr = RAMA'({req_q, ff[SW-1:0]});
                        wdata.client = client_reg; wdata.prio = prio_reg;
                        wdata.count = (kind_reg == K_BREQ && !bus_busy_reg_q) ?
                                      count_reg - 8'd1 : count_reg;
                        wdata.stamp = stamp_reg;
                        stamp_next = stamp_reg + 16'd1;
                        vset = 1'b1; vq = req_q; vs = ff[SW-1:0];
                    end
                end else begin
                    vq = sq_reg; vs = bi_reg;
                    if (bs_reg.count > 8'd1) begin
                        we = 1'b1; waddr = RAMA'({sq_reg, bi_reg});
                        wdata = bs_reg;
                        wdata.count = bs_reg.count - 8'd1;
                        wdata.stamp = stamp_reg;
                        stamp_next = stamp_reg + 16'd1;
                    end else begin
                        vclr = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cfg_reg      <= 3'd2;
            gpu_busy_reg <= '0;
            bus_busy_reg <= 1'b0;
            stamp_reg    <= '0;
            rv_reg       <= 1'b0;
            for (int q = 0; q < NQ; q++) valid_reg[q] <= '0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) cfg_reg <= cfg_wdata;
            gpu_busy_reg <= gpu_busy_next;
            bus_busy_reg <= bus_busy_next;
            stamp_reg    <= stamp_next;
            rv_reg       <= (state_reg == S_SCAN || state_reg == S_SCAN2) && !sc_reg[SW];
            if (vset) valid_reg[vq][vs] <= 1'b1;
            if (vclr) valid_reg[vq][vs] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg   <= s_tuser;
            any_reg    <= s_tdata[0];
            idx_reg    <= s_tdata[2:1];
            client_reg <= s_tdata[18:3];
            prio_reg   <= s_tdata[26:19];
            count_reg  <= s_tdata[34:27];
        end
        if (state_reg == S_DECIDE) bus_busy_reg_q <= bus_busy_reg;
        rs_reg  <= sc_reg[SW-1:0];
        out_reg <= out_next;
        sq_reg <= sq_next; sc_reg <= sc_next;
        bf_reg <= bf_next; bi_reg <= bi_next; bs_reg <= bs_next; ba_reg <= ba_next;
        uf_reg <= uf_next; ui_reg <= ui_next; us_reg <= us_next;
    end

    `PRGS_ASSERT_IMP(a_busy_out, aclk, aresetn, m_tvalid, !s_tready)
    `PRGS_ASSERT_IMP(a_grant_st, aclk, aresetn, m_tvalid && m_tdata[0],
        m_tdata[30:28] == ST_OK || m_tdata[30:28] == ST_FULL)
    `PRGS_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `PRGS_ASSERT_IMP(a_bus_unit0, aclk, aresetn, m_tvalid && m_tuser,
        m_tdata[18:17] == 2'd0 && m_tdata[19] == 1'b0)
endmodule
